/* rtl/pctp_pkg.sv */
// Shared types and constants of the page cache tag and policy engine.
// Used by the core, pctp_alu and pctp_order; depends on nothing else.

package pctp_pkg;

    // Default number of cache slots.
    localparam int CACHE_ENTRIES_DEF = 16;

    // Field widths.
    localparam int ADDR_W     = 52;
    localparam int TIME_W     = 32;
    localparam int SHIFT_W    = 5;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    // Stream packing.
    localparam int IN_DATA_W  = 88;
    localparam int IN_PAD_W   = IN_DATA_W - ADDR_W - TIME_W;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - ADDR_W - SLOT_OUT_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 52;

    // Slot field of an order command, wide enough for the largest cache.
    localparam int SLOT_CMD_W = 6;

    // Shared arithmetic unit width: one bit above an address for the range sum.
    localparam int ALU_W = ADDR_W + 1;

    // Register reset values.
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'(12);
    localparam logic [TIME_W-1:0]  MAX_AGE_RST    = '0;
    localparam logic [ADDR_W-1:0]  MAX_PHYS_RST   = '1;
    localparam logic               RANGE_ON_RST   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SHIFT = 2'd0,
        CFG_MAX_AGE    = 2'd1,
        CFG_MAX_PHYS   = 2'd2,
        CFG_RANGE_ON   = 2'd3
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_REFRESH  = 3'd1,
        ST_FILL     = 3'd2,
        ST_EVICT    = 3'd3,
        ST_MISALIGN = 3'd4,
        ST_RANGE    = 3'd5,
        ST_REMOVE   = 3'd6
    } status_t;

    // Updates of the recency bookkeeping.
    typedef enum logic [2:0] {
        ORD_NONE   = 3'd0,
        ORD_REMOVE = 3'd1,
        ORD_TOUCH  = 3'd2,
        ORD_EVICT  = 3'd3,
        ORD_INSERT = 3'd4
    } ord_op_t;

    typedef struct packed {
        ord_op_t               op;
        logic [SLOT_CMD_W-1:0] slot;
    } ord_cmd_t;

endpackage

/* rtl/page_cache_tag_policy_core.sv */
// Top level of the page cache tag and policy engine: sequencer, tag and time RAMs.
// Depends on pctp_pkg, pctp_ram, pctp_alu and pctp_order.
//
//   Channel   Direction  Handshake                  Contents
//   s_axis    in         tvalid/tready              request: tuser kind, tdata addr+time
//   m_axis    out        tvalid/tready, tlast       result: status, address, slot
//   cfg       in         cfg_we (no wait)           register index and write data
//
// A misaligned request skips the scan. Otherwise the tags are compared one
// slot per cycle by the shared add/compare unit: the scan stops at the slot that
// holds the page or runs over all N slots, and a fill into a full cache first evicts entries.
// Reset clears all slots at once.
// Only one request is in work at a time; each result waits in the output
// register for the consumer, and a stalled consumer holds the sequencer.

module page_cache_tag_policy_core #(
    parameter int CACHE_ENTRIES = pctp_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [51:0] page_addr, [83:52] now_time, [87:84] zero
    input  logic [pctp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] status, [54:3] result_addr, [58:55] slot, [63:59] zero
    output logic [pctp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [pctp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pctp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pctp_pkg::*;

    localparam int N      = CACHE_ENTRIES;
    localparam int SLOT_W = $clog2(N);
    localparam int CNT_W  = $clog2(N + 1);
    localparam int HALF   = N / 2;

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_SCAN       = 6'b000010,
        S_DECIDE     = 6'b000100,
        S_EVICT_FIND = 6'b001000,
        S_EVICT_EMIT = 6'b010000,
        S_FILL       = 6'b100000
    } state_t;

    // Control registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [SHIFT_W-1:0]  page_shift_reg;
    logic [TIME_W-1:0]   max_age_reg;
    logic [ADDR_W-1:0]   max_phys_reg;
    logic                range_on_reg;

    // Request and working payload registers.
    logic                req_reg, req_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                misalign_reg, misalign_next;
    logic [SLOT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [TIME_W-1:0]   hit_time_reg, hit_time_next;
    logic [SLOT_W-1:0]   victim_reg, victim_next;

    // Output payload registers.
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic                out_last_reg, out_last_next;

    // Datapath wires.
    logic [ADDR_W-1:0]   in_addr;
    logic [TIME_W-1:0]   in_time;
    logic                out_free;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic                tag_we;
    logic [ADDR_W-1:0]   tag_rdata;
    logic                time_we;
    logic [SLOT_W-1:0]   time_waddr;
    logic [TIME_W-1:0]   time_rdata;
    logic [ALU_W-1:0]    alu_a, alu_b, alu_c;
    logic                alu_cin, alu_wrap, alu_gt, alu_eq;
    ord_cmd_t            ord_cmd;
    logic [N-1:0]        valid;
    logic [CNT_W-1:0]    count;
    logic [SLOT_W-1:0]   victim;
    logic [SLOT_W-1:0]   free_slot;
    logic                emit;
    status_t             emit_status;
    logic [ADDR_W-1:0]   emit_addr;
    logic [SLOT_W-1:0]   emit_slot;
    logic                emit_last;

    assign in_addr  = s_axis_tdata[ADDR_W-1:0];
    assign in_time  = s_axis_tdata[ADDR_W+TIME_W-1:ADDR_W];
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Tag and refresh time stores.
    pctp_ram #(.WIDTH(ADDR_W), .DEPTH(N)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (free_slot),
        .wdata (addr_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (tag_rdata)
    );

    pctp_ram #(.WIDTH(TIME_W), .DEPTH(N)) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (now_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (time_rdata)
    );

    pctp_alu u_alu (
        .op_a     (alu_a),
        .op_b     (alu_b),
        .op_c     (alu_c),
        .carry_in (alu_cin),
        .wrap32   (alu_wrap),
        .gt       (alu_gt),
        .eq       (alu_eq)
    );

    pctp_order #(.N(N)) u_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ord_cmd),
        .valid     (valid),
        .count     (count),
        .victim    (victim),
        .free_slot (free_slot)
    );

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        now_next      = now_reg;
        misalign_next = misalign_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_time_next = hit_time_reg;
        victim_next   = victim_reg;

        ram_re     = 1'b0;
        ram_raddr  = scan_idx_reg[SLOT_W-1:0];
        tag_we     = 1'b0;
        time_we    = 1'b0;
        time_waddr = hit_idx_reg;
        ord_cmd    = '{op: ORD_NONE, slot: '0};

        // Shared unit defaults to the tag compare of the scan.
        alu_a    = {1'b0, tag_rdata};
        alu_b    = '0;
        alu_c    = {1'b0, addr_reg};
        alu_cin  = 1'b0;
        alu_wrap = 1'b0;

        emit        = 1'b0;
        emit_status = ST_HIT;
        emit_addr   = addr_reg;
        emit_slot   = '0;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next      = s_axis_tuser;
                    addr_next     = in_addr;
                    now_next      = in_time;
                    misalign_next = (in_addr & ~({ADDR_W{1'b1}} << page_shift_reg)) != '0;
                    hit_next      = 1'b0;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    if ((in_addr & ~({ADDR_W{1'b1}} << page_shift_reg)) != '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Read one slot per cycle and compare the one read last cycle.
                ram_re       = scan_idx_reg < CNT_W'(N);
                cmp_vld_next = scan_idx_reg < CNT_W'(N);
                cmp_idx_next = scan_idx_reg[SLOT_W-1:0];
                if (scan_idx_reg < CNT_W'(N))
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && valid[cmp_idx_reg] && alu_eq)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = cmp_idx_reg;
                    hit_time_next = time_rdata;
                    state_next    = S_DECIDE;
                end
                else if (cmp_vld_reg && cmp_idx_reg == SLOT_W'(N - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // Age of the hit entry, modulo the time width.
                alu_a    = ALU_W'(now_reg);
                alu_b    = ALU_W'(~hit_time_reg);
                alu_c    = ALU_W'(max_age_reg);
                alu_cin  = 1'b1;
                alu_wrap = 1'b1;
                if (!misalign_reg && !req_reg && !hit_reg)
                begin
                    if (count == CNT_W'(N))
                    begin
                        state_next = S_EVICT_FIND;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (misalign_reg)
                    begin
                        emit_status = ST_MISALIGN;
                    end
                    else if (req_reg)
                    begin
                        emit_status = ST_REMOVE;
                        if (hit_reg)
                        begin
                            emit_slot = hit_idx_reg;
                            ord_cmd   = '{op: ORD_REMOVE, slot: SLOT_CMD_W'(hit_idx_reg)};
                        end
                    end
                    else
                    begin
                        emit_slot = hit_idx_reg;
                        if (max_age_reg != '0 && alu_gt)
                        begin
                            emit_status = ST_REFRESH;
                            time_we     = 1'b1;
                            ord_cmd     = '{op: ORD_TOUCH, slot: SLOT_CMD_W'(hit_idx_reg)};
                        end
                        else
                        begin
                            emit_status = ST_HIT;
                        end
                    end
                end
            end
            S_EVICT_FIND:
            begin
                // Fetch the tag of the oldest entry.
                ram_re      = 1'b1;
                ram_raddr   = victim;
                victim_next = victim;
                state_next  = S_EVICT_EMIT;
            end
            S_EVICT_EMIT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = ST_EVICT;
                    emit_addr   = tag_rdata;
                    emit_slot   = victim_reg;
                    emit_last   = 1'b0;
                    ord_cmd     = '{op: ORD_EVICT, slot: SLOT_CMD_W'(victim_reg)};
                    if (count > CNT_W'(HALF + 1))
                    begin
                        state_next = S_EVICT_FIND;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                // Range check: page end against the physical bound.
                alu_a = {1'b0, addr_reg};
                alu_b = ALU_W'(1) << page_shift_reg;
                alu_c = {1'b0, max_phys_reg};
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (range_on_reg && alu_gt)
                    begin
                        emit_status = ST_RANGE;
                    end
                    else
                    begin
                        emit_status = ST_FILL;
                        emit_slot   = free_slot;
                        tag_we      = 1'b1;
                        time_we     = 1'b1;
                        time_waddr  = free_slot;
                        ord_cmd     = '{op: ORD_INSERT, slot: SLOT_CMD_W'(free_slot)};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register loads on a result and empties when the transaction completes.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_addr_next   = emit_addr;
            out_slot_next   = SLOT_OUT_W'(emit_slot);
            out_last_next   = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            page_shift_reg <= PAGE_SHIFT_RST;
            max_age_reg    <= MAX_AGE_RST;
            max_phys_reg   <= MAX_PHYS_RST;
            range_on_reg   <= RANGE_ON_RST;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_PAGE_SHIFT: page_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                    CFG_MAX_AGE:    max_age_reg    <= cfg_wdata[TIME_W-1:0];
                    CFG_MAX_PHYS:   max_phys_reg   <= cfg_wdata[ADDR_W-1:0];
                    CFG_RANGE_ON:   range_on_reg   <= cfg_wdata[0];
                    default:        range_on_reg   <= range_on_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        now_reg        <= now_next;
        misalign_reg   <= misalign_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_time_reg   <= hit_time_next;
        victim_reg     <= victim_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_slot_reg, out_addr_reg, out_status_reg};

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_status_reg == ST_EVICT) |-> !m_axis_tlast)
        else $error("eviction result marked as final");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction left no work in progress");

    a_evict_only_above_half: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT_FIND) |-> (count > CNT_W'(HALF)))
        else $error("eviction started at or below half capacity");

endmodule

/* rtl/pctp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.

module pctp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pctp_alu.sv */
// Shared add and compare unit of the page cache engine.
// Depends on pctp_pkg for its width.

module pctp_alu (
    input  logic [pctp_pkg::ALU_W-1:0] op_a,
    input  logic [pctp_pkg::ALU_W-1:0] op_b,
    input  logic [pctp_pkg::ALU_W-1:0] op_c,
    input  logic                       carry_in,
    input  logic                       wrap32,
    output logic                       gt,
    output logic                       eq
);
    import pctp_pkg::*;

    logic [ALU_W-1:0] sum;
    logic [ALU_W-1:0] res;

    // One adder; the result may be cut to the time width for modular age.
    assign sum = op_a + op_b + ALU_W'(carry_in);
    assign res = wrap32 ? ALU_W'(sum[TIME_W-1:0]) : sum;

    // Magnitude compare of the sum and equality of the raw operand.
    assign gt = res > op_c;
    assign eq = op_a == op_c;

endmodule

/* rtl/pctp_order.sv */
// Valid bits, recency ranks and entry count of the page cache slots.
// Depends on pctp_pkg for the order command type.

module pctp_order #(
    parameter int N      = pctp_pkg::CACHE_ENTRIES_DEF,
    localparam int SLOT_W = $clog2(N),
    localparam int CNT_W  = $clog2(N + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pctp_pkg::ord_cmd_t  cmd,
    output logic [N-1:0]        valid,
    output logic [CNT_W-1:0]    count,
    output logic [SLOT_W-1:0]   victim,
    output logic [SLOT_W-1:0]   free_slot
);
    import pctp_pkg::*;

    // Rank 0 is the most recent slot; rank count-1 is the oldest.
    logic [SLOT_W-1:0] rank_reg  [N];
    logic [SLOT_W-1:0] rank_next [N];
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] sel_rank;
    logic [SLOT_W-1:0] tail_rank;

    assign sel       = cmd.slot[SLOT_W-1:0];
    assign sel_rank  = rank_reg[sel];
    assign tail_rank = SLOT_W'(count_reg - CNT_W'(1));

    // Rank, valid bit and count updates for each kind of command.
    always_comb
    begin
        rank_next  = rank_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        case (cmd.op)
            ORD_REMOVE:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] > sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] - SLOT_W'(1);
                    end
                end
                valid_next[sel] = 1'b0;
                count_next      = count_reg - CNT_W'(1);
            end
            ORD_TOUCH:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] + SLOT_W'(1);
                    end
                end
                rank_next[sel] = '0;
            end
            ORD_EVICT:
            begin
                valid_next[sel] = 1'b0;
                count_next      = count_reg - CNT_W'(1);
            end
            ORD_INSERT:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + SLOT_W'(1);
                    end
                end
                rank_next[sel]  = '0;
                valid_next[sel] = 1'b1;
                count_next      = count_reg + CNT_W'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // The oldest valid slot and the lowest free slot.
    always_comb
    begin
        victim    = '0;
        free_slot = '0;
        for (int i = 0; i < N; i++)
        begin
            if (valid_reg[i] && rank_reg[i] == tail_rank)
            begin
                victim = SLOT_W'(i);
            end
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    assign valid = valid_reg;
    assign count = count_reg;

    // The count tracks the number of valid slots and never passes capacity.
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count differs from number of valid slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("entry count above capacity");

    // A refresh, removal or eviction never touches a slot that is not valid.
    a_touch_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ORD_TOUCH || cmd.op == ORD_REMOVE || cmd.op == ORD_EVICT)
            |-> valid_reg[sel])
        else $error("order update on an invalid slot");

endmodule
